// ===== rtl/core/afd_pkg.sv =====
// Package for the API frame deframer with checksum.
// Holds the byte constants, result kind codes and the result record type.
// No dependencies.
package afd_pkg;

  localparam logic [7:0] FRAME_DELIM      = 8'h7E;
  localparam logic [7:0] SUM_GOOD         = 8'hFF;
  localparam logic [7:0] HUNT_LIMIT_RESET = 8'd30;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
  } result_t;

endpackage

// ===== rtl/core/afd_in_reg.sv =====
// Input register stage of the frame deframer.
// Captures one received byte per request; depends on no package.
module afd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

// ===== rtl/core/afd_parser.sv =====
// Frame parser state machine: hunting, header, payload and checksum phases.
// Depends on afd_pkg for constants, kind codes and result_t.
module afd_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  input  logic [7:0]      hunt_limit,
  output logic            res_valid,
  output afd_pkg::result_t res
);

  import afd_pkg::*;

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_LEN_HI = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_CHECK  = 3'd4;

  logic [2:0] phase_r;
  logic [2:0] phase_nxt;
  logic [7:0] miss_r;
  logic [7:0] miss_nxt;
  logic [7:0] count_r;
  logic [7:0] count_nxt;
  logic [7:0] seen_r;
  logic [7:0] seen_nxt;
  logic [7:0] sum_r;
  logic [7:0] sum_nxt;
  logic [7:0] sum_add;

  assign sum_add = sum_r + rx_byte;

  always_comb begin
    phase_nxt = phase_r;
    miss_nxt  = miss_r;
    count_nxt = count_r;
    seen_nxt  = seen_r;
    sum_nxt   = sum_r;
    res_valid = 1'b0;
    res       = '0;
    case (phase_r)
      PH_LEN_HI: begin
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        count_nxt = rx_byte;
        seen_nxt  = '0;
        phase_nxt = (rx_byte == 8'd0) ? PH_CHECK : PH_BODY;
      end
      PH_BODY: begin
        sum_nxt   = sum_add;
        seen_nxt  = seen_r + 8'd1;
        if (seen_nxt == count_r) begin
          phase_nxt = PH_CHECK;
        end
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.data_byte    = rx_byte;
        res.byte_index   = seen_r;
        res.frame_length = count_r;
      end
      PH_CHECK: begin
        sum_nxt          = sum_add;
        phase_nxt        = PH_HUNT;
        miss_nxt         = '0;
        res_valid        = 1'b1;
        res.kind         = (sum_add == SUM_GOOD) ? KIND_GOOD : KIND_BAD;
        res.frame_length = count_r;
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == FRAME_DELIM) begin
          miss_nxt  = '0;
          sum_nxt   = '0;
          seen_nxt  = '0;
          phase_nxt = PH_LEN_HI;
        end else if (miss_r >= hunt_limit) begin
          miss_nxt  = '0;
          res_valid = 1'b1;
          res.kind  = KIND_TIMEOUT;
        end else begin
          miss_nxt = miss_r + 8'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      miss_r  <= '0;
      count_r <= '0;
      seen_r  <= '0;
      sum_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      miss_r  <= miss_nxt;
      count_r <= count_nxt;
      seen_r  <= seen_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

// ===== rtl/core/afd_out_reg.sv =====
// Result register of the frame deframer, held until the receiver takes it.
// Depends on afd_pkg for result_t.
module afd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  afd_pkg::result_t res,
  output logic             can_take,
  output logic             out_valid,
  input  logic             out_ready,
  output afd_pkg::result_t out_res
);

  import afd_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign can_take  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/core/api_frame_deframer_checksum_top.sv =====
// Top level of the API frame deframer with checksum.
// Depends on afd_pkg, afd_in_reg, afd_parser and afd_out_reg.
//
// Usage: one received byte enters per request on the in_ channel (valid and
// ready). Payload bytes come out on the out_ channel with their index and the
// frame length; the checksum byte produces a good or bad frame result, and too
// many non-delimiter bytes while hunting produce a timeout result. Header bytes,
// delimiters and tolerated misses produce no result.
// Path: a byte accepted into the input register is parsed when the result register
// can take a result, and any result that it makes then shows on out_valid.
// Throughput: one byte per cycle while out_ready does not hold a waiting result,
// set by the parser step between the input register and the result register.
// Stall: while a result waits and out_ready is low, the parser holds and in_ready
// falls once the input register is full; no result is lost or repeated.
// Reset: rst_n is synchronous and active low. It empties both registers, puts the
// parser into hunting with cleared counters and sets hunt_limit to 30.
// cfg_wr_en writes cfg_wr_data into hunt_limit at once; write it only when idle.
module api_frame_deframer_checksum_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_byte_index,
  output logic [7:0] out_frame_length,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  import afd_pkg::*;

  logic [7:0] hunt_limit_r;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       can_take;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_limit_r <= HUNT_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      hunt_limit_r <= cfg_wr_data;
    end
  end

  assign step = s1_valid && can_take;

  afd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (step),
    .s1_valid   (s1_valid),
    .s1_byte    (s1_byte)
  );

  afd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rx_byte    (s1_byte),
    .hunt_limit (hunt_limit_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  afd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_data_byte    = out_res.data_byte;
  assign out_byte_index   = out_res.byte_index;
  assign out_frame_length = out_res.frame_length;

  a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_PAYLOAD |-> out_byte_index < out_frame_length)
    else $error("payload index not below frame length");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |-> out_data_byte == 8'd0
      && out_byte_index == 8'd0)
    else $error("non-payload result carries data");

  a_timeout_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TIMEOUT |-> out_frame_length == 8'd0)
    else $error("timeout result carries a frame length");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

endmodule

// ===== sim/api_frame_deframer_checksum_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for api_frame_deframer_checksum_top.
// Drives received bytes, predicts the frame results and compares them per field.
// Depends on afd_pkg and the RTL of the deframer.
module api_frame_deframer_checksum_top_tb;
  import afd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;

  typedef enum logic [2:0] {
    SEEK_DELIM,
    SKIP_LEN_HI,
    TAKE_LEN_LO,
    TAKE_PAYLOAD,
    TAKE_CHECKSUM
  } deframe_phase_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic [7:0] out_byte_index;
  logic [7:0] out_frame_length;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  result_t        deframed_q[$];
  deframe_phase_t rx_phase;
  logic [7:0]     hunt_limit_q;
  logic [7:0]     miss_cnt;
  logic [7:0]     payload_len;
  logic [7:0]     payload_pos;
  logic [7:0]     frame_sum;

  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_left;
  int cycle_cnt;
  int errors;
  int bytes_sent;
  int results_seen;
  int payload_seen_cnt;
  int good_cnt;
  int bad_cnt;
  int timeout_cnt;

  api_frame_deframer_checksum_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               deframed_q.size());
      $display("[api_frame_deframer_checksum_top] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    if (errors <= 40) begin
      $display("Mismatch on %s at result %0d: got 0x%02h, expected 0x%02h.",
               what, results_seen, got, want);
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (rx_phase)
      SKIP_LEN_HI: begin
        rx_phase = TAKE_LEN_LO;
      end
      TAKE_LEN_LO: begin
        payload_len = b;
        payload_pos = 8'd0;
        rx_phase = (b == 8'd0) ? TAKE_CHECKSUM : TAKE_PAYLOAD;
      end
      TAKE_PAYLOAD: begin
        r.kind = KIND_PAYLOAD;
        r.data_byte = b;
        r.byte_index = payload_pos;
        r.frame_length = payload_len;
        frame_sum = frame_sum + b;
        payload_pos = payload_pos + 8'd1;
        if (payload_pos == payload_len) begin
          rx_phase = TAKE_CHECKSUM;
        end
        deframed_q.push_back(r);
      end
      TAKE_CHECKSUM: begin
        frame_sum = frame_sum + b;
        r.kind = (frame_sum == SUM_GOOD) ? KIND_GOOD : KIND_BAD;
        r.frame_length = payload_len;
        rx_phase = SEEK_DELIM;
        miss_cnt = 8'd0;
        deframed_q.push_back(r);
      end
      default: begin
        rx_phase = SEEK_DELIM;
        if (b == FRAME_DELIM) begin
          miss_cnt = 8'd0;
          frame_sum = 8'd0;
          payload_pos = 8'd0;
          rx_phase = SKIP_LEN_HI;
        end else if (miss_cnt >= hunt_limit_q) begin
          miss_cnt = 8'd0;
          r.kind = KIND_TIMEOUT;
          deframed_q.push_back(r);
        end else begin
          miss_cnt = miss_cnt + 8'd1;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (deframed_q.size() == 0) begin
        report_mismatch("unexpected result kind", {6'd0, out_kind}, 8'd0);
      end else begin
        want = deframed_q.pop_front();
        if (out_kind !== want.kind)
          report_mismatch("kind", {6'd0, out_kind}, {6'd0, want.kind});
        if (out_data_byte !== want.data_byte)
          report_mismatch("data_byte", out_data_byte, want.data_byte);
        if (out_byte_index !== want.byte_index)
          report_mismatch("byte_index", out_byte_index, want.byte_index);
        if (out_frame_length !== want.frame_length)
          report_mismatch("frame_length", out_frame_length, want.frame_length);
        case (want.kind)
          KIND_PAYLOAD: payload_seen_cnt++;
          KIND_GOOD:    good_cnt++;
          KIND_BAD:     bad_cnt++;
          default:      timeout_cnt++;
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_hunt_limit(input logic [7:0] v);
    wait_idle();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    hunt_limit_q = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'($urandom);
  endtask

  task automatic send_frame(input logic [7:0] len, input bit good_sum);
    logic [7:0] s;
    logic [7:0] b;
    s = 8'd0;
    send_byte(FRAME_DELIM);
    send_byte(8'($urandom));
    send_byte(len);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if ($urandom_range(15) == 0) b = FRAME_DELIM;
      s = s + b;
      send_byte(b);
    end
    if (good_sum) send_byte(SUM_GOOD - s);
    else send_byte(8'($urandom));
  endtask

  task automatic send_misses(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (b == FRAME_DELIM) b = 8'h00;
      send_byte(b);
    end
  endtask

  task automatic test_directed_frames();
    send_byte(FRAME_DELIM);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h00);
    send_byte(FRAME_DELIM);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(FRAME_DELIM);
    send_byte(8'h12);
    send_byte(8'h03);
    send_byte(FRAME_DELIM);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
  endtask

  task automatic test_hunt_limit();
    write_hunt_limit(8'd0);
    send_byte(8'h00);
    send_byte(FRAME_DELIM);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h00);
    write_hunt_limit(8'd2);
    send_byte(8'h01);
    send_byte(8'hFE);
    send_byte(FRAME_DELIM);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    write_hunt_limit(8'd5);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    write_hunt_limit(8'd1);
    send_byte(8'hFF);
  endtask

  task automatic test_backpressure();
    write_hunt_limit(8'd30);
    @(negedge clk);
    hold_left = 300;
    send_frame(8'd60, 1'b1);
    send_misses(31);
    wait_idle();
  endtask

  task automatic test_random(input int n_bytes, input logic [7:0] limit,
                             input int snd_pct, input int rcv_pct);
    int target;
    int pick;
    logic [7:0] len;
    write_hunt_limit(limit);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        if ($urandom_range(99) == 0) len = 8'd255;
        else if ($urandom_range(9) == 0) len = 8'($urandom_range(40));
        else len = 8'($urandom_range(8));
        send_frame(len, $urandom_range(99) < 80);
      end else if (pick < 88) begin
        for (int i = $urandom_range(1, 6); i > 0; i--) send_byte(8'($urandom));
      end else begin
        send_misses(int'(hunt_limit_q) + 1);
      end
    end
    wait_idle();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    hold_left = 0;
    cycle_cnt = 0;
    errors = 0;
    bytes_sent = 0;
    results_seen = 0;
    payload_seen_cnt = 0;
    good_cnt = 0;
    bad_cnt = 0;
    timeout_cnt = 0;
    snd_idle_pct = 6;
    rcv_idle_pct = 82;
    rx_phase = SEEK_DELIM;
    hunt_limit_q = HUNT_LIMIT_RESET;
    miss_cnt = 8'd0;
    payload_len = 8'd0;
    payload_pos = 8'd0;
    frame_sum = 8'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_frames();
    test_hunt_limit();
    test_random(450, 8'd30, 6, 82);
    test_backpressure();
    test_random(450, 8'd0, 82, 6);
    test_random(250, 8'd255, 0, 0);
    test_random(200, 8'($urandom_range(1, 12)), 0, 0);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d bytes under limits 0 to 255 and three idling mixes; checked %0d results.",
             bytes_sent, results_seen);
    $display("Results: %0d payload bytes, %0d good frames, %0d bad frames, %0d timeouts.",
             payload_seen_cnt, good_cnt, bad_cnt, timeout_cnt);
    if (errors == 0 && deframed_q.size() == 0) begin
      $display("[api_frame_deframer_checksum_top] OK");
    end else begin
      $display("[api_frame_deframer_checksum_top] ERROR");
    end
    $finish;
  end

endmodule
